// File: design/mm3bh_pkg.sv
// ----------------------------------------------------------------------------
// mm3bh_pkg
// Shared types and constants for the MurmurHash3 x86_32 bucket hash block.
// ----------------------------------------------------------------------------
package mm3bh_pkg;

   // Hash constants
   localparam logic [31:0] SEED_AT_RESET = 32'h160e0b17;
   localparam logic [31:0] MIX_C1        = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2        = 32'h1b873593;
   localparam logic [31:0] MIX_ADD       = 32'he6546b64;
   localparam logic [31:0] FIN_C1        = 32'h85ebca6b;
   localparam logic [31:0] FIN_C2        = 32'hc2b2ae35;
   localparam logic [5:0]  BITS_AT_RESET = 6'd32;

   // Register indexes on the configuration port
   localparam logic CSR_HASH_SEED   = 1'b0;
   localparam logic CSR_BUCKET_BITS = 1'b1;

   // Request byte counts
   localparam logic [2:0] BYTES_NONE  = 3'd0;
   localparam logic [2:0] BYTES_ONE   = 3'd1;
   localparam logic [2:0] BYTES_TWO   = 3'd2;
   localparam logic [2:0] BYTES_THREE = 3'd3;
   localparam logic [2:0] BYTES_FOUR  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCR1,
      ST_SCR2,
      ST_MIX,
      ST_FIN1,
      ST_FIN2,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_in;
      logic do_mul1;
      logic do_mul2;
      logic do_mix;
      logic do_fin1;
      logic do_fin2;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_empty;
      logic req_last;
      logic cur_last;
      logic out_busy;
   } status_type;

   function automatic logic [31:0] rotl13(input logic [31:0] v);
      return {v[18:0], v[31:19]};
   endfunction

   function automatic logic [31:0] rotl15(input logic [31:0] v);
      return {v[16:0], v[31:17]};
   endfunction

endpackage

// File: design/mm3bh_ctrl.sv
// ----------------------------------------------------------------------------
// mm3bh_ctrl
// Sequencer for the hash: steps each request with key bytes through scramble
// and mix, finalises on the last request, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mm3bh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mm3bh_pkg::status_type status,
   output mm3bh_pkg::cmd_type    cmd
);

   mm3bh_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm3bh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mm3bh_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (!status.req_empty) begin
                  state_in = mm3bh_pkg::ST_SCR1;
               end else if (status.req_last) begin
                  state_in = mm3bh_pkg::ST_FIN1;
               end
            end
         end
         mm3bh_pkg::ST_SCR1: state_in = mm3bh_pkg::ST_SCR2;
         mm3bh_pkg::ST_SCR2: state_in = mm3bh_pkg::ST_MIX;
         mm3bh_pkg::ST_MIX: begin
            state_in = status.cur_last ? mm3bh_pkg::ST_FIN1 : mm3bh_pkg::ST_IDLE;
         end
         mm3bh_pkg::ST_FIN1: state_in = mm3bh_pkg::ST_FIN2;
         mm3bh_pkg::ST_FIN2: state_in = mm3bh_pkg::ST_DONE;
         mm3bh_pkg::ST_DONE: begin
            if (!status.out_busy) begin
               state_in = mm3bh_pkg::ST_IDLE;
            end
         end
         default: state_in = mm3bh_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         mm3bh_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         mm3bh_pkg::ST_SCR1: cmd.do_mul1 = 1'b1;
         mm3bh_pkg::ST_SCR2: cmd.do_mul2 = 1'b1;
         mm3bh_pkg::ST_MIX:  cmd.do_mix  = 1'b1;
         mm3bh_pkg::ST_FIN1: cmd.do_fin1 = 1'b1;
         mm3bh_pkg::ST_FIN2: cmd.do_fin2 = 1'b1;
         mm3bh_pkg::ST_DONE: cmd.load_out = !status.out_busy;
         default: begin
            req_tready = 1'b0;
            cmd        = '0;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // A request with key bytes always goes to the scramble stage
   a_bytes_scramble: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !status.req_empty) |=> state_ff == mm3bh_pkg::ST_SCR1)
      else $error("request with bytes did not start scramble");

   // An empty last request goes straight to finalise
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.req_empty && status.req_last)
      |=> state_ff == mm3bh_pkg::ST_FIN1)
      else $error("empty last request did not finalise");

   // The result is never loaded over a waiting one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !status.out_busy)
      else $error("result loaded while output busy");
`endif

endmodule

// File: design/mm3bh_datapath.sv
// ----------------------------------------------------------------------------
// mm3bh_datapath
// Hash datapath: request capture, scramble multipliers, mix recurrence,
// fmix32 finaliser, bucket mask, output register and configuration.
// ----------------------------------------------------------------------------
module mm3bh_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [39:0]           req_tdata,  // data_word[31:0], valid_bytes[34:32], zero pad
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,  // hash_value[31:0], bucket_index[63:32]
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata,
   input  mm3bh_pkg::cmd_type    cmd,
   output mm3bh_pkg::status_type status
);

   logic [31:0] seed_ff;
   logic [5:0]  bits_ff;
   logic [31:0] word_ff;
   logic        full_ff;
   logic        last_ff;
   logic [31:0] len_ff;
   logic [31:0] h_ff;
   logic [31:0] k_ff;
   logic [31:0] fin_ff;
   logic [31:0] out_hash_ff;
   logic [31:0] out_bucket_ff;
   logic        out_valid_ff;

   logic [31:0] req_word;
   logic [2:0]  req_bytes;
   logic [2:0]  bytes_sat;
   logic [31:0] keep;
   logic [31:0] mul1_in;
   logic [31:0] mul2_in;
   logic [31:0] mix_x;
   logic [31:0] mix_r;
   logic [31:0] mix_in;
   logic [31:0] fin1_x;
   logic [31:0] fin1_in;
   logic [31:0] fin2_x;
   logic [31:0] fin2_in;
   logic [31:0] hash_out;
   logic [31:0] bucket_mask;

   assign req_word  = req_tdata[31:0];
   assign req_bytes = req_tdata[34:32];

   // Saturate the byte count and mask off bytes beyond it
   always_comb begin
      bytes_sat = (req_bytes > mm3bh_pkg::BYTES_FOUR) ? mm3bh_pkg::BYTES_FOUR : req_bytes;
      case (bytes_sat)
         mm3bh_pkg::BYTES_NONE:  keep = 32'h0000_0000;
         mm3bh_pkg::BYTES_ONE:   keep = 32'h0000_00ff;
         mm3bh_pkg::BYTES_TWO:   keep = 32'h0000_ffff;
         mm3bh_pkg::BYTES_THREE: keep = 32'h00ff_ffff;
         default:                keep = 32'hffff_ffff;
      endcase
   end

   // Scramble multipliers, one per stage
   assign mul1_in = word_ff * mm3bh_pkg::MIX_C1;
   assign mul2_in = mm3bh_pkg::rotl15(k_ff) * mm3bh_pkg::MIX_C2;

   // Mix: full words get the rotate, times five and add; tails only the XOR
   assign mix_x  = h_ff ^ k_ff;
   assign mix_r  = mm3bh_pkg::rotl13(mix_x);
   assign mix_in = full_ff ? ((mix_r << 2) + mix_r + mm3bh_pkg::MIX_ADD) : mix_x;

   // Finaliser, split at its two multiplications
   assign fin1_x  = h_ff ^ len_ff;
   assign fin1_in = (fin1_x ^ (fin1_x >> 16)) * mm3bh_pkg::FIN_C1;
   assign fin2_x  = fin_ff ^ (fin_ff >> 13);
   assign fin2_in = fin2_x * mm3bh_pkg::FIN_C2;
   assign hash_out = fin_ff ^ (fin_ff >> 16);

   // Bucket mask: keep bits below the bucket bit count
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         bucket_mask[i] = (bits_ff > 6'(i));
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mm3bh_pkg::SEED_AT_RESET;
         bits_ff <= mm3bh_pkg::BITS_AT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            mm3bh_pkg::CSR_HASH_SEED:   seed_ff <= csr_wdata;
            mm3bh_pkg::CSR_BUCKET_BITS: bits_ff <= csr_wdata[5:0];
            default: seed_ff <= seed_ff;
         endcase
      end
   end

   // Key state: running hash and byte length
   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff   <= mm3bh_pkg::SEED_AT_RESET;
         len_ff <= '0;
      end else if (cmd.load_in) begin
         len_ff <= len_ff + {29'd0, bytes_sat};
      end else if (cmd.do_mix) begin
         h_ff <= mix_in;
      end else if (cmd.do_fin1) begin
         h_ff   <= seed_ff;
         len_ff <= '0;
      end
   end

   // Capture the request and hold intermediate products
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         word_ff <= req_word & keep;
         full_ff <= (bytes_sat == mm3bh_pkg::BYTES_FOUR);
         last_ff <= req_tlast;
      end
      if (cmd.do_mul1) begin
         k_ff <= mul1_in;
      end else if (cmd.do_mul2) begin
         k_ff <= mul2_in;
      end
      if (cmd.do_fin1) begin
         fin_ff <= fin1_in;
      end else if (cmd.do_fin2) begin
         fin_ff <= fin2_in;
      end
      if (cmd.load_out) begin
         out_hash_ff   <= hash_out;
         out_bucket_ff <= hash_out & bucket_mask;
      end
   end

   // Output valid: set on load, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_bucket_ff, out_hash_ff};

   assign status.req_empty = (bytes_sat == mm3bh_pkg::BYTES_NONE);
   assign status.req_last  = req_tlast;
   assign status.cur_last  = last_ff;
   assign status.out_busy  = out_valid_ff && !rsp_tready;

`ifndef NO_ASSERTIONS
   // Finalise reloads the seed and clears the length
   a_reload: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_fin1 && !csr_wr_en) |=> (h_ff == $past(seed_ff) && len_ff == '0))
      else $error("key state not reloaded after finalise");

   // A loaded result is presented next cycle
   a_present: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> out_valid_ff)
      else $error("loaded result not presented");

   // The bucket index never has bits outside the hash
   a_bucket_subset: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_bucket_ff & ~out_hash_ff) == '0))
      else $error("bucket index not a subset of hash");
`endif

endmodule

// File: design/murmur3_32_bucket_hash.sv
// A request with key bytes passes through the two-stage scramble and the mix
// step; a last request then also goes through the two-stage finaliser, while an
// empty last request goes straight to the finaliser and an empty word that is
// not last is ignored. A finished result waits while the output is stalled, and
// a new request is accepted only when the block is back in idle.
// Reset (sync, active high) loads seed 0x160e0b17, bucket bits 32, clears length.
// ----------------------------------------------------------------------------
// murmur3_32_bucket_hash
// Streaming MurmurHash3 x86_32 over little-endian key words, with the hash
// masked to a power-of-two bucket index.
// ----------------------------------------------------------------------------
module murmur3_32_bucket_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // data_word[31:0], valid_bytes[34:32], zero pad
   input  logic        req_tlast,  // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // hash_value[31:0], bucket_index[63:32]
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   mm3bh_pkg::cmd_type    cmd;
   mm3bh_pkg::status_type status;

   // Sequencer
   mm3bh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath
   mm3bh_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash3 bucket hash testbench
// Streams keys as little-endian words into murmur3_32_bucket_hash, predicts
// each finalised hash and bucket index in step with the accepted requests,
// and compares every returned result field by field. Both stream sides idle
// and stall at random, and the seed and bucket width change between phases.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [31:0] bucket_index;
   } bucket_hash_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // data_word[31:0], valid_bytes[34:32], zero pad
   logic        req_tlast = 1'b0;  // last_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;  // hash_value[31:0], bucket_index[63:32]
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   // Predictor state
   logic [31:0] key_seed;
   logic [5:0]  bucket_bits;
   logic [31:0] partial_hash;
   logic [31:0] byte_count;

   bucket_hash_type pending_hashes[$];
   int          fail_count = 0;
   int          requests_sent = 0;
   bit          steady_run = 1'b0;
   int          hold_cycles = 0;

   murmur3_32_bucket_hash i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Word scramble: multiply, rotate left by 15, multiply
   function automatic logic [31:0] scramble_key(input logic [31:0] k);
      logic [31:0] t;
      t = k * mm3bh_pkg::MIX_C1;
      t = {t[16:0], t[31:17]};
      return t * mm3bh_pkg::MIX_C2;
   endfunction

   // Avalanche the final hash
   function automatic logic [31:0] fmix_hash(input logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * mm3bh_pkg::FIN_C1;
      h = h ^ (h >> 13);
      h = h * mm3bh_pkg::FIN_C2;
      return h ^ (h >> 16);
   endfunction

   // Fold one accepted request into the running hash; queue a result on last
   function automatic void absorb_word(input logic [31:0] w, input logic [2:0] nb_in,
                                       input logic lst);
      logic [31:0]     h;
      logic [31:0]     keep;
      logic [31:0]     mask;
      logic [2:0]      nb;
      logic [5:0]      bits;
      bucket_hash_type r;
      nb = (nb_in > mm3bh_pkg::BYTES_FOUR) ? mm3bh_pkg::BYTES_FOUR : nb_in;
      h  = partial_hash;
      if (nb == mm3bh_pkg::BYTES_FOUR) begin
         h = h ^ scramble_key(w);
         h = {h[18:0], h[31:19]} * 32'd5 + mm3bh_pkg::MIX_ADD;
      end else if (nb != mm3bh_pkg::BYTES_NONE) begin
         keep = (32'h1 << (8 * nb)) - 32'h1;
         h = h ^ scramble_key(w & keep);
      end
      byte_count   = byte_count + {29'd0, nb};
      partial_hash = h;
      if (lst) begin
         h    = fmix_hash(h ^ byte_count);
         bits = (bucket_bits > 6'd32) ? 6'd32 : bucket_bits;
         mask = (bits >= 6'd32) ? 32'hffffffff : ((32'h1 << bits) - 32'h1);
         r.hash_value   = h;
         r.bucket_index = h & mask;
         pending_hashes.push_back(r);
         partial_hash = key_seed;
         byte_count   = '0;
      end
   endfunction

   // Offer one request, with a random gap first, and hold it until accepted
   task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
      while (!steady_run && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, nb, w};
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      absorb_word(w, nb, lst);
      if (nb != mm3bh_pkg::BYTES_NONE || lst) requests_sent++;
   endtask

   // Send a whole key: full words, then a tail of 0 to 3 bytes
   task automatic send_key(input int n_full, input int tail);
      for (int i = 0; i < n_full; i++)
         send_word($urandom, mm3bh_pkg::BYTES_FOUR, (tail == 0) && (i == n_full - 1));
      if (tail != 0 || n_full == 0)
         send_word($urandom, tail[2:0], 1'b1);
   endtask

   // Drop valid, wait for every outstanding result, then let the block go idle
   task automatic settle_block;
      req_tvalid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == mm3bh_pkg::CSR_HASH_SEED) key_seed = value;
      else bucket_bits = value[5:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= steady_run || ($urandom_range(99) >= 10);
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      bucket_hash_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hashes.size() == 0) begin
            $error("unexpected result: hash_value %h bucket_index %h",
                   rsp_tdata[31:0], rsp_tdata[63:32]);
            fail_count++;
         end else begin
            exp_r = pending_hashes.pop_front();
            if (rsp_tdata[31:0] !== exp_r.hash_value) begin
               $error("hash_value: expected %h, got %h", exp_r.hash_value, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[63:32] !== exp_r.bucket_index) begin
               $error("bucket_index: expected %h, got %h",
                      exp_r.bucket_index, rsp_tdata[63:32]);
               fail_count++;
            end
         end
      end
   end

   // Reset values: empty key and one full word under the reset seed
   task automatic test_reset_defaults;
      send_word(32'h0, mm3bh_pkg::BYTES_NONE, 1'b1);
      send_word(32'hffffffff, mm3bh_pkg::BYTES_FOUR, 1'b1);
      settle_block();
   endtask

   // Tails, saturated byte counts, ignored words, partial words mid-key
   task automatic test_key_tails;
      write_csr(mm3bh_pkg::CSR_HASH_SEED, 32'h0);
      send_word(32'hffffffff, mm3bh_pkg::BYTES_ONE, 1'b1);
      send_word(32'h0, mm3bh_pkg::BYTES_TWO, 1'b1);
      send_word($urandom, mm3bh_pkg::BYTES_THREE, 1'b1);
      send_word($urandom, mm3bh_pkg::BYTES_FOUR, 1'b0);
      send_word(32'hffffffff, mm3bh_pkg::BYTES_THREE, 1'b1);
      send_word($urandom, 3'd5, 1'b1);
      send_word($urandom, 3'd6, 1'b0);
      send_word($urandom, 3'd7, 1'b1);
      // word with no bytes inside a key is skipped
      send_word(32'hffffffff, mm3bh_pkg::BYTES_NONE, 1'b0);
      send_word($urandom, mm3bh_pkg::BYTES_TWO, 1'b1);
      // partial word not marked last, key carries on
      send_word(32'hffffffff, mm3bh_pkg::BYTES_ONE, 1'b0);
      send_word($urandom, mm3bh_pkg::BYTES_FOUR, 1'b1);
      settle_block();
   endtask

   // Bucket widths at and beyond the extremes
   task automatic test_bucket_widths;
      logic [5:0] widths[4];
      widths = '{6'd0, 6'd1, 6'd31, 6'd63};
      write_csr(mm3bh_pkg::CSR_HASH_SEED, 32'hffffffff);
      foreach (widths[i]) begin
         write_csr(mm3bh_pkg::CSR_BUCKET_BITS, {26'b0, widths[i]});
         send_word($urandom, mm3bh_pkg::BYTES_FOUR, 1'b1);
         settle_block();
      end
   endtask

   // A seed written within a key only takes effect on the next key
   task automatic test_seed_mid_key;
      write_csr(mm3bh_pkg::CSR_BUCKET_BITS, 32'd32);
      send_word($urandom, mm3bh_pkg::BYTES_FOUR, 1'b0);
      settle_block();
      write_csr(mm3bh_pkg::CSR_HASH_SEED, $urandom);
      send_word($urandom, mm3bh_pkg::BYTES_TWO, 1'b1);
      send_word($urandom, mm3bh_pkg::BYTES_FOUR, 1'b1);
      settle_block();
   endtask

   // Hold the receiver off while short keys keep arriving
   task automatic test_backpressure;
      hold_cycles = 400;
      for (int i = 0; i < 40; i++)
         send_key($urandom_range(0, 1), $urandom_range(0, 3));
      settle_block();
   endtask

   // Random keys in phases, each with its own seed and bucket width
   task automatic test_random_keys;
      int target;
      int pick;
      logic [31:0] seed_val;
      logic [5:0]  width_val;
      for (int phase = 0; phase < 6; phase++) begin
         pick = $urandom_range(0, 3);
         seed_val  = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffffffff : $urandom;
         pick = $urandom_range(0, 4);
         width_val = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd32 : (pick == 2) ? 6'd63 :
                     6'($urandom_range(0, 63));
         write_csr(mm3bh_pkg::CSR_HASH_SEED, seed_val);
         write_csr(mm3bh_pkg::CSR_BUCKET_BITS, {26'b0, width_val});
         steady_run = (phase == 2);
         target = requests_sent + 310;
         while (requests_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 85)
               send_key(($urandom_range(9) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4),
                        $urandom_range(0, 3));
            else
               send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         end
         // close any key left open by noise before the next settings
         send_word($urandom, mm3bh_pkg::BYTES_NONE, 1'b1);
         settle_block();
      end
      steady_run = 1'b0;
   endtask

   initial begin
      key_seed     = mm3bh_pkg::SEED_AT_RESET;
      bucket_bits  = mm3bh_pkg::BITS_AT_RESET;
      partial_hash = mm3bh_pkg::SEED_AT_RESET;
      byte_count   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_key_tails();
      test_bucket_widths();
      test_seed_mid_key();
      test_backpressure();
      test_random_keys();
      settle_block();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
design/mm3bh_pkg.sv
design/mm3bh_ctrl.sv
design/mm3bh_datapath.sv
design/murmur3_32_bucket_hash.sv
tb/sv/testbench.sv
